// ===== src/sosse_pkg.sv =====
// Package for the second-order Euler step block: types, constants, sine table and helpers.
`default_nettype none

package sosse_pkg;

    // Fixed-point format and table size.
    localparam int FRAC_BITS        = 16;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int DATA_W     = 32;
    localparam int STEP_W     = 31;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MUL_W      = DATA_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = PROD_W - FRAC_BITS + 2;
    localparam int DIV_W      = DATA_W;
    localparam int DIVISOR_W  = PERIOD_W;
    localparam int K_SCALE    = 4 * SINE_TABLE_DEPTH;
    localparam int K_W        = $clog2(K_SCALE);
    localparam int SIN_IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);

    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [1:0] {
        KIND_SQUARE = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_SINE   = 2'd2,
        KIND_ONE    = 2'd3
    } kind_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A0      = 3'd0,
        REG_COEF_A1      = 3'd1,
        REG_COEF_B0      = 3'd2,
        REG_COEF_B1      = 3'd3,
        REG_STEP_SIZE    = 3'd4,
        REG_INPUT_PERIOD = 3'd5,
        REG_INPUT_KIND   = 3'd6
    } cfg_reg_e_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_a0;
        logic signed [DATA_W-1:0] coef_a1;
        logic signed [DATA_W-1:0] coef_b0;
        logic signed [DATA_W-1:0] coef_b1;
        logic [STEP_W-1:0]        step_size;
        logic [PERIOD_W-1:0]      input_period;
        kind_e_t                  input_kind;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] time_index;
        logic              restart;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] response;
        logic                     overflow;
    } out_beat_t;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LATCH_PH,
        OP_START_K,
        OP_EXC,
        OP_MUL_A0,
        OP_MUL_A1,
        OP_MUL_HX1,
        OP_SAT_DX,
        OP_MUL_HDX,
        OP_UPD_X1,
        OP_MUL_B0,
        OP_MUL_B1,
        OP_SUM_Y,
        OP_OUT
    } dp_op_e_t;

    typedef struct packed {
        dp_op_e_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_k;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_PH,
        ST_START_K,
        ST_DIV_K,
        ST_EXC,
        ST_MUL_A0,
        ST_MUL_A1,
        ST_MUL_HX1,
        ST_SAT_DX,
        ST_MUL_HDX,
        ST_UPD_X1,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_SUM_Y,
        ST_OUT
    } state_e_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     ovf;
    } sat_t;

    typedef logic [FRAC_BITS:0] sine_tab_t [0:SINE_TABLE_DEPTH];

    // Quarter-wave sine entry: Taylor series in unsigned Q30, rounded half up.
    function automatic logic [FRAC_BITS:0] sine_entry(input int unsigned j);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x    = (PI_Q30 * 64'(j)) / 64'(2 * SINE_TABLE_DEPTH);
        term = x;
        sum  = $signed(x);
        for (int unsigned n = 1; n <= 13; n++) begin
            term = ((((term * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rnd = ($unsigned(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (rnd > (64'd1 << FRAC_BITS)) begin
            rnd = 64'd1 << FRAC_BITS;
        end
        return rnd[FRAC_BITS:0];
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
            tab[j] = sine_entry(j);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    // Product shifted right with rounding toward minus infinity.
    function automatic logic signed [ACC_W-1:0] fl_shr(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p >>> FRAC_BITS;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_acc(input logic signed [DATA_W-1:0] v);
        return {{(ACC_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_mul(input logic signed [DATA_W-1:0] v);
        return {v[DATA_W-1], v};
    endfunction

    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
        lo = {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
        if (v > hi) begin
            r.value = hi[DATA_W-1:0];
            r.ovf   = 1'b1;
        end else if (v < lo) begin
            r.value = lo[DATA_W-1:0];
            r.ovf   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/second_order_state_space_euler_step.sv =====
// Top level of the forward Euler step for a second-order state-space system.
//
//  channel   direction  handshake                 payload
//  s_*       in         s_valid / s_ready         in_beat_t  {time_index, restart}
//  m_*       out        m_valid / m_ready         out_beat_t {response, overflow}
//  cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// An input beat with the square, step or constant excitation passes one division; the
// sine needs a second one. Each division runs in the radix-2 divider, and the step
// sequence then goes through the one shared 33x33 multiplier.
// Reset is synchronous and active low; it clears both state variables and loads the
// register defaults. A stalled result waits in the output register; the next beat is
// accepted meanwhile and its own result waits in the final step until the register frees.
`default_nettype none

module second_order_state_space_euler_step
    import sosse_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Register writes are always taken. Software must write only while the block is idle; the
    // block does not enforce this, and the datapath reads the registers without a shadow copy.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_a0      <= DATA_W'(65536);
            cfg_reg.coef_a1      <= DATA_W'(65536);
            cfg_reg.coef_b0      <= DATA_W'(65536);
            cfg_reg.coef_b1      <= '0;
            cfg_reg.step_size    <= STEP_W'(655);
            cfg_reg.input_period <= PERIOD_W'(100);
            cfg_reg.input_kind   <= KIND_SQUARE;
        end else if (cfg_valid && cfg_ready) begin
            // An index past the last register is ignored.
            unique case (cfg_index)
                REG_COEF_A0:      cfg_reg.coef_a0      <= cfg_data;
                REG_COEF_A1:      cfg_reg.coef_a1      <= cfg_data;
                REG_COEF_B0:      cfg_reg.coef_b0      <= cfg_data;
                REG_COEF_B1:      cfg_reg.coef_b1      <= cfg_data;
                REG_STEP_SIZE:    cfg_reg.step_size    <= cfg_data[STEP_W-1:0];
                REG_INPUT_PERIOD: cfg_reg.input_period <= cfg_data[PERIOD_W-1:0];
                REG_INPUT_KIND:   cfg_reg.input_kind   <= kind_e_t'(cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    // The controller sequences the divisions and products; it sees only s_valid,
    // the divider done pulse, whether the kind is sine and whether the output is free.
    sosse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the state, the multiplier, the divider and the output register.
    sosse_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_beat (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== src/sosse_div.sv =====
// Radix-2 restoring divider that yields quotient and remainder one bit per cycle.
`default_nettype none

module sosse_div
    import sosse_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          quotient,
    output logic [DIVISOR_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0]     count_reg;
    logic                 done_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;

    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = diff[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end else begin
            rem_next = trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            if (start) begin
                count_reg <= CNT_W'(DIV_W);
                done_reg  <= 1'b0;
            end else if (count_reg != '0) begin
                count_reg <= count_reg - 1'b1;
                done_reg  <= (count_reg == CNT_W'(1));
            end else begin
                done_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (count_reg != '0) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/sosse_datapath.sv =====
// Datapath: state registers, shared multiplier, accumulator, excitation and output register.
`default_nettype none

module sosse_datapath
    import sosse_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_t      cfg,
    input  wire in_beat_t  in_beat,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     status,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    localparam logic [K_W-1:0]       K_Q1  = K_W'(SINE_TABLE_DEPTH);
    localparam logic [K_W-1:0]       K_Q2  = K_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [K_W-1:0]       K_Q3  = K_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [SIN_IDX_W-1:0] D_IDX = SIN_IDX_W'(SINE_TABLE_DEPTH);

    logic signed [DATA_W-1:0] x0_reg;
    logic signed [DATA_W-1:0] x1_reg;
    logic signed [DATA_W-1:0] dx1_reg;
    logic signed [DATA_W-1:0] u_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DATA_W-1:0]        t_reg;
    logic [PERIOD_W-1:0]      ph_reg;
    logic                     ovf_reg;
    logic                     m_valid_reg;
    out_beat_t                out_reg;

    logic [PERIOD_W-1:0]      period;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;
    logic [DIVISOR_W-1:0]     div_rem;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     mul_en;
    logic signed [ACC_W-1:0]  prod_fl;

    logic [K_W-1:0]           k;
    logic [1:0]               quad;
    logic [K_W-1:0]           r;
    logic [SIN_IDX_W-1:0]     idx;
    logic signed [DATA_W-1:0] sine_mag;
    logic signed [DATA_W-1:0] u_next;

    sat_t sat_acc;
    sat_t sat_x0;
    sat_t sat_x1;

    // A period of zero behaves as a period of one.
    assign period = (cfg.input_period == '0) ? PERIOD_W'(1) : cfg.input_period;

    assign div_start    = (cmd.op == OP_LOAD) || (cmd.op == OP_START_K);
    assign div_dividend = (cmd.op == OP_LOAD) ? in_beat.time_index
                                              : DIV_W'(ph_reg) * DIV_W'(K_SCALE);

    sosse_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (period),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sine lookup: quadrant from the scaled phase, mirrored index in odd quadrants.
    always_comb begin
        k = div_quo[K_W-1:0];
        if (k >= K_Q3) begin
            quad = 2'd3;
            r    = k - K_Q3;
        end else if (k >= K_Q2) begin
            quad = 2'd2;
            r    = k - K_Q2;
        end else if (k >= K_Q1) begin
            quad = 2'd1;
            r    = k - K_Q1;
        end else begin
            quad = 2'd0;
            r    = k;
        end
        idx      = quad[0] ? (D_IDX - r[SIN_IDX_W-1:0]) : r[SIN_IDX_W-1:0];
        sine_mag = DATA_W'(SINE_TAB[idx]);
    end

    always_comb begin
        unique case (cfg.input_kind)
            KIND_SQUARE: u_next = (ph_reg < (period >> 1)) ? ONE_FX : -ONE_FX;
            KIND_STEP:   u_next = (t_reg == '0) ? '0 : ONE_FX;
            KIND_SINE:   u_next = quad[1] ? -sine_mag : sine_mag;
            KIND_ONE:    u_next = ONE_FX;
        endcase
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_en = 1'b1;
        unique case (cmd.op)
            OP_MUL_A0: begin
                mul_a = ext_mul(cfg.coef_a0);
                mul_b = ext_mul(x0_reg);
            end
            OP_MUL_A1: begin
                mul_a = ext_mul(cfg.coef_a1);
                mul_b = ext_mul(x1_reg);
            end
            OP_MUL_HX1: begin
                mul_a = {2'b00, cfg.step_size};
                mul_b = ext_mul(x1_reg);
            end
            OP_MUL_HDX: begin
                mul_a = {2'b00, cfg.step_size};
                mul_b = ext_mul(dx1_reg);
            end
            OP_MUL_B0: begin
                mul_a = ext_mul(cfg.coef_b0);
                mul_b = ext_mul(x0_reg);
            end
            OP_MUL_B1: begin
                mul_a = ext_mul(cfg.coef_b1);
                mul_b = ext_mul(x1_reg);
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    assign prod_fl = fl_shr(prod_reg);
    assign sat_acc = sat32(acc_reg);
    assign sat_x0  = sat32(ext_acc(x0_reg) + prod_fl);
    assign sat_x1  = sat32(ext_acc(x1_reg) + prod_fl);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // State variables, overflow flag and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg      <= '0;
            x1_reg      <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD: begin
                    ovf_reg <= 1'b0;
                    if (in_beat.restart) begin
                        x0_reg <= '0;
                        x1_reg <= '0;
                    end
                end
                OP_SAT_DX: begin
                    x0_reg  <= sat_x0.value;
                    ovf_reg <= ovf_reg | sat_x0.ovf | sat_acc.ovf;
                end
                OP_UPD_X1: begin
                    x1_reg  <= sat_x1.value;
                    ovf_reg <= ovf_reg | sat_x1.ovf;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD:     t_reg <= in_beat.time_index;
            OP_LATCH_PH: ph_reg <= div_rem;
            OP_EXC:      u_reg <= u_next;
            OP_MUL_A1:   acc_reg <= ext_acc(u_reg) - prod_fl;
            OP_MUL_HX1:  acc_reg <= acc_reg - prod_fl;
            OP_SAT_DX:   dx1_reg <= sat_acc.value;
            OP_MUL_B1:   acc_reg <= prod_fl;
            OP_SUM_Y:    acc_reg <= acc_reg + prod_fl;
            OP_OUT: begin
                out_reg.response <= sat_acc.value;
                out_reg.overflow <= ovf_reg | sat_acc.ovf;
            end
            default: begin
            end
        endcase
    end

    assign status.div_done = div_done;
    assign status.need_k   = (cfg.input_kind == KIND_SINE);
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== src/sosse_ctrl.sv =====
// Controller state machine that sequences divisions, products and the result beat.
`default_nettype none

module sosse_ctrl
    import sosse_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    state_e_t state_reg;
    state_e_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DIV_PH;
                end
            end
            ST_DIV_PH: begin
                if (status.div_done) begin
                    cmd.op     = OP_LATCH_PH;
                    state_next = status.need_k ? ST_START_K : ST_EXC;
                end
            end
            ST_START_K: begin
                cmd.op     = OP_START_K;
                state_next = ST_DIV_K;
            end
            ST_DIV_K: begin
                if (status.div_done) begin
                    state_next = ST_EXC;
                end
            end
            ST_EXC: begin
                cmd.op     = OP_EXC;
                state_next = ST_MUL_A0;
            end
            ST_MUL_A0: begin
                cmd.op     = OP_MUL_A0;
                state_next = ST_MUL_A1;
            end
            ST_MUL_A1: begin
                cmd.op     = OP_MUL_A1;
                state_next = ST_MUL_HX1;
            end
            ST_MUL_HX1: begin
                cmd.op     = OP_MUL_HX1;
                state_next = ST_SAT_DX;
            end
            ST_SAT_DX: begin
                cmd.op     = OP_SAT_DX;
                state_next = ST_MUL_HDX;
            end
            ST_MUL_HDX: begin
                cmd.op     = OP_MUL_HDX;
                state_next = ST_UPD_X1;
            end
            ST_UPD_X1: begin
                cmd.op     = OP_UPD_X1;
                state_next = ST_MUL_B0;
            end
            ST_MUL_B0: begin
                cmd.op     = OP_MUL_B0;
                state_next = ST_MUL_B1;
            end
            ST_MUL_B1: begin
                cmd.op     = OP_MUL_B1;
                state_next = ST_SUM_Y;
            end
            ST_SUM_Y: begin
                cmd.op     = OP_SUM_Y;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sosse_checker.sv =====
// Port-level checker for the Euler step block and its bind to the top level.
`default_nettype none

module sosse_checker
    import sosse_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_beat_t m_data
);

    // Reset drops any pending result.
    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // One beat at a time: the input side closes right after an acceptance.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is in progress");

    // A new result cannot appear in the cycle right after an acceptance.
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind second_order_state_space_euler_step sosse_checker u_sosse_checker (.*);

`default_nettype wire

// ===== tb/second_order_state_space_euler_step_tb.sv =====
// Self-checking testbench for the second-order forward Euler step block.
module second_order_state_space_euler_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sosse_pkg::*;

    // Clock, reset and run length.
    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 10;
    localparam int LIMIT_NS         = 4_000_000;
    localparam int SETTLE_CYCLES    = 200;

    // Shape of the random part.
    localparam int PHASES           = 8;
    localparam int ITEMS_PER_PHASE  = 66;
    localparam int MAX_GAP          = 40;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int HOLD_PHASE       = 2;
    localparam int PAUSE_PHASE      = 5;

    // Register index past the end of the map; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // The scoreboard carries its own model of the system: both state variables, the
    // register file and the quarter-wave sine table. Every accepted input beat advances
    // the model and queues the response it must produce; every result beat is compared
    // against the oldest queued response.
    class euler_step_scoreboard;
        longint      coef_a0;
        longint      coef_a1;
        longint      coef_b0;
        longint      coef_b1;
        longint      step_h;
        int unsigned period;
        kind_e_t     kind;
        longint      pos_x0;
        longint      vel_x1;
        bit          ovf_seen;
        longint      sine_q16[0:SINE_TABLE_DEPTH];
        out_beat_t   expected_responses[$];
        int          mismatches;
        int          results_seen;

        function new();
            longint unsigned ang;
            longint unsigned term;
            longint unsigned div;
            longint          acc;
            // Taylor series of sin(pi*j/(2*DEPTH)) in unsigned Q30, rounded half up.
            for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
                ang  = (PI_Q30 * longint'(j)) / (2 * SINE_TABLE_DEPTH);
                term = ang;
                acc  = longint'(ang);
                for (int n = 1; n <= 13; n++) begin
                    div  = (2 * n) * (2 * n + 1);
                    term = ((((term * ang) >> 30) * ang) >> 30) / div;
                    if (n % 2 == 1) begin
                        acc = acc - longint'(term);
                    end else begin
                        acc = acc + longint'(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                acc = (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
                sine_q16[j] = (acc > longint'(ONE_FX)) ? longint'(ONE_FX) : acc;
            end
            // Register defaults after reset: a0 = a1 = b0 = 1.0, b1 = 0.
            coef_a0      = longint'(ONE_FX);
            coef_a1      = longint'(ONE_FX);
            coef_b0      = longint'(ONE_FX);
            coef_b1      = 0;
            step_h       = 655;
            period       = 100;
            kind         = KIND_SQUARE;
            pos_x0       = 0;
            vel_x1       = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_COEF_A0:      coef_a0 = longint'($signed(val));
                REG_COEF_A1:      coef_a1 = longint'($signed(val));
                REG_COEF_B0:      coef_b0 = longint'($signed(val));
                REG_COEF_B1:      coef_b1 = longint'($signed(val));
                REG_STEP_SIZE:    step_h  = longint'({1'b0, val[STEP_W-1:0]});
                REG_INPUT_PERIOD: period  = 32'(val[PERIOD_W-1:0]);
                REG_INPUT_KIND:   kind    = kind_e_t'(val[1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) begin
                ovf_seen = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                ovf_seen = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint excitation_level(logic [DATA_W-1:0] t);
            longint unsigned p;
            longint unsigned ph;
            longint unsigned k;
            longint unsigned quad;
            longint unsigned r;
            longint          one;
            one = longint'(ONE_FX);
            // A zero period behaves like a period of one.
            p  = (period == 0) ? 1 : period;
            ph = t % p;
            case (kind)
                KIND_SQUARE: return (ph < p / 2) ? one : -one;
                KIND_STEP:   return (t == 0) ? 0 : one;
                KIND_SINE: begin
                    k    = (ph * 4 * SINE_TABLE_DEPTH) / p;
                    quad = (k / SINE_TABLE_DEPTH) % 4;
                    r    = k % SINE_TABLE_DEPTH;
                    case (quad)
                        0:       return sine_q16[r];
                        1:       return sine_q16[SINE_TABLE_DEPTH - r];
                        2:       return -sine_q16[r];
                        default: return -sine_q16[SINE_TABLE_DEPTH - r];
                    endcase
                end
                default:     return one;
            endcase
        endfunction

        function void advance_model(in_beat_t beat);
            longint    drive;
            longint    dvel;
            longint    npos;
            longint    nvel;
            longint    y;
            out_beat_t want;
            ovf_seen = 1'b0;
            if (beat.restart) begin
                pos_x0 = 0;
                vel_x1 = 0;
            end
            drive = excitation_level(beat.time_index);
            // Products are exact in 64 bits; >>> floors them toward minus infinity.
            dvel = clamp32(-((coef_a0 * pos_x0) >>> FRAC_BITS)
                           - ((coef_a1 * vel_x1) >>> FRAC_BITS) + drive);
            npos = clamp32(pos_x0 + ((step_h * vel_x1) >>> FRAC_BITS));
            nvel = clamp32(vel_x1 + ((step_h * dvel) >>> FRAC_BITS));
            pos_x0 = npos;
            vel_x1 = nvel;
            y = clamp32(((coef_b0 * pos_x0) >>> FRAC_BITS) + ((coef_b1 * vel_x1) >>> FRAC_BITS));
            want.response = y[DATA_W-1:0];
            want.overflow = ovf_seen;
            expected_responses.push_back(want);
        endfunction

        function void report(string what);
            mismatches++;
            $display("[%0t] ERROR result %0d: %s", $time, results_seen, what);
        endfunction

        function void check_response(out_beat_t got);
            out_beat_t want;
            results_seen++;
            if (expected_responses.size() == 0) begin
                report($sformatf("unexpected result, response %h overflow %b",
                                 got.response, got.overflow));
                return;
            end
            want = expected_responses.pop_front();
            if (got.response !== want.response) begin
                report($sformatf("response %h, expected %h", got.response, want.response));
            end
            if (got.overflow !== want.overflow) begin
                report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
            end
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction
    endclass

    // Block ports. Every input holds a known value from time zero.
    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_beat_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    euler_step_scoreboard sb;

    // Idling controls. The sender's idle chance is used only by the stimulus process; the
    // receiver's stall chance and the long-hold request are written with nonblocking
    // assignments so the receiver process reads them without a race.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req_cnt   = 0;
    int hold_ack_cnt   = 0;
    int hold_left      = 0;

    second_order_state_space_euler_step u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    // Result side. Outputs are sampled at the rising edge, before the block's own
    // nonblocking updates land, so a beat is taken exactly when both sides were high.
    // Ready is redrawn every cycle but during a long hold, which is counted out here.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_response(m_data);
        end
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Number of idle cycles after a beat; each cycle idles with the current chance.
    function automatic int draw_gap();
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            g++;
        end
        return g;
    endfunction

    // Offers one input beat and holds it until accepted. Valid is left high when no gap
    // follows, so the next call replaces the payload in the same step without a drop.
    task automatic send_item(input logic [DATA_W-1:0] t, input logic clear_state);
        in_beat_t beat;
        int       gap;
        beat.time_index = t;
        beat.restart    = clear_state;
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.advance_model(beat);
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering beats and waits until every queued response has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // One register write. Like send_item it leaves valid high; the caller lowers it
    // after the last write of a group.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, val);
    endtask

    // Directed part: waveform edges, every excitation kind, degenerate periods, a zero
    // step, the ignored register index and a fully saturating coefficient set.
    task automatic run_directed();
        // Reset setting: square wave, period 100; both sides of the half-period edge.
        send_item(0, 1'b1);
        send_item(49, 1'b0);
        send_item(50, 1'b0);
        send_item(99, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        wait_for_results();
        write_reg(REG_INPUT_KIND, KIND_STEP);
        cfg_valid <= 1'b0;
        send_item(0, 1'b1);
        send_item(1, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        // Sine at the start of each quadrant and in between.
        wait_for_results();
        write_reg(REG_INPUT_KIND, KIND_SINE);
        cfg_valid <= 1'b0;
        send_item(0, 1'b1);
        send_item(25, 1'b0);
        send_item(50, 1'b0);
        send_item(75, 1'b0);
        send_item(99, 1'b0);
        send_item(37, 1'b0);
        wait_for_results();
        write_reg(REG_INPUT_KIND, KIND_ONE);
        cfg_valid <= 1'b0;
        send_item(5, 1'b1);
        // A zero period must act like a period of one for both periodic kinds.
        wait_for_results();
        write_reg(REG_INPUT_PERIOD, 0);
        write_reg(REG_INPUT_KIND, KIND_SQUARE);
        cfg_valid <= 1'b0;
        send_item(3, 1'b0);
        wait_for_results();
        write_reg(REG_INPUT_KIND, KIND_SINE);
        cfg_valid <= 1'b0;
        send_item(7, 1'b0);
        wait_for_results();
        write_reg(REG_INPUT_PERIOD, 1);
        cfg_valid <= 1'b0;
        send_item(9, 1'b0);
        wait_for_results();
        write_reg(REG_INPUT_KIND, KIND_SQUARE);
        cfg_valid <= 1'b0;
        send_item(8, 1'b0);
        // Largest period; the upper data bits must be dropped.
        wait_for_results();
        write_reg(REG_INPUT_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_INPUT_KIND, KIND_SINE);
        cfg_valid <= 1'b0;
        send_item(16383, 1'b0);
        send_item(65534, 1'b0);
        // With a zero step the state must hold; the out-of-range write changes nothing.
        wait_for_results();
        write_reg(REG_STEP_SIZE, 0);
        write_reg(REG_INPUT_KIND, KIND_ONE);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_item(11, 1'b0);
        // Extreme coefficients and the largest step drive every stage into saturation.
        wait_for_results();
        write_reg(REG_COEF_A0, 32'h8000_0000);
        write_reg(REG_COEF_A1, 32'h7FFF_FFFF);
        write_reg(REG_COEF_B0, 32'h7FFF_FFFF);
        write_reg(REG_COEF_B1, 32'h8000_0000);
        write_reg(REG_STEP_SIZE, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_item(1, 1'b0);
        send_item(2, 1'b0);
        send_item(3, 1'b0);
    endtask

    // Rewrites every register for a new phase. Most values are moderate so the system
    // actually evolves; a fraction are extremes or fully random words.
    task automatic configure_phase(input int ph);
        logic [DATA_W-1:0] val;
        wait_for_results();
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = $urandom();
                default: val = 32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536);
            endcase
            write_reg(CFG_IDX_W'(REG_COEF_A0 + i), val);
        end
        case ($urandom_range(9))
            0:       val = 0;
            1:       val = 32'h7FFF_FFFF;
            2:       val = $urandom();
            default: val = $urandom_range(100, 20000);
        endcase
        write_reg(REG_STEP_SIZE, val);
        case ($urandom_range(9))
            0:       val = 0;
            1:       val = 1;
            2:       val = 32'h0000_FFFF;
            3:       val = $urandom();
            default: val = $urandom_range(2, 400);
        endcase
        write_reg(REG_INPUT_PERIOD, val);
        // Each kind gets two phases; the unused upper data bits are random.
        val = $urandom();
        val[1:0] = kind_e_t'(ph % 4);
        write_reg(REG_INPUT_KIND, val);
        if ($urandom_range(1) == 1) begin
            write_reg(REG_UNUSED, $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    // One random phase: mostly runs of consecutive time indexes that start with a
    // restart, so the waveform and the state evolve as in real use; the rest is noise
    // with random time indexes and restart flags.
    task automatic run_phase(input int ph);
        int                left;
        int                len;
        bit                paused;
        logic [DATA_W-1:0] t0;
        configure_phase(ph);
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 66; end
            default: begin send_idle_pct = 37; recv_stall_pct <= 37; end
        endcase
        // Hold off the receiver long enough that the block backs up into its input.
        if (ph == HOLD_PHASE) begin
            hold_req_cnt <= hold_req_cnt + 1;
        end
        left   = ITEMS_PER_PHASE;
        paused = 1'b0;
        while (left > 0) begin
            // Once, stop sending halfway and let the block drain completely.
            if (ph == PAUSE_PHASE && !paused && left < ITEMS_PER_PHASE / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
            if ($urandom_range(4) != 0) begin
                len = $urandom_range(4, 30);
                if (len > left) begin
                    len = left;
                end
                t0 = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 300);
                for (int i = 0; i < len; i++) begin
                    send_item(t0 + i, i == 0);
                end
            end else begin
                len = 1;
                send_item($urandom(), 1'($urandom_range(1)));
            end
            left -= len;
        end
    endtask

    // Main sequence: reset once, directed beats, random phases, then drain and judge.
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            run_phase(ph);
        end
        wait_for_results();
        // Any stray beat arriving late still lands in the checker during this window.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #(LIMIT_NS);
        $display("[%0t] ERROR timeout with %0d responses outstanding", $time, sb.pending());
        $display("Mismatches found");
        $finish;
    end

endmodule
